// File: hw/rtl/qcl_pkg.sv
package qcl_pkg;

  localparam int unsigned DEF_MAX_BLOCK_ROWS = 12;
  localparam int unsigned DEF_MAX_ROW_WEIGHT = 24;

  localparam logic [6:0] Z_RESET     = 7'd96;
  localparam logic [6:0] Z_MIN       = 7'd24;
  localparam logic [6:0] Z_MAX       = 7'd96;
  localparam logic [6:0] Z_STEP_MASK = 7'd3;

  // floor(p / 96) = floor(floor(p / 32) / 3), the divide by 3 done as * 171 >> 9
  localparam int unsigned SCALE_SHIFT       = 5;
  localparam int unsigned SCALE_RECIP       = 171;
  localparam int unsigned SCALE_RECIP_SHIFT = 9;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_EXPAND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_BAD,
    ST_WALK
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic mod_sub;
    logic start_walk;
    logic issue;
    logic issue_bad;
  } dp_cmd_t;

  typedef struct packed {
    logic adv;
    logic z_bad;
    logic row_skip;
    logic d_ge_z;
    logic k_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/qc_ldpc_expansion_address_gen_core.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   req_type, block_row, entry_slot, entry_shift,
//                                            entry_column, row_end, sub_row
// out       output     out_valid / out_stall check_node_index, var_node_index, last,
//                                            bad_config
// cfg       input      cfg_valid / cfg_ready cfg_data (expansion_factor)
//
// An expand item is captured, its sub-row is reduced by repeated subtract of z, then the
// row walk issues one table read per cycle while out is not stalled into a four-stage
// pipeline (read, multiply, reciprocal scale, modulo and add), so results leave one per
// cycle while out is not stalled. With a bad expansion_factor a single bad_config item is
// issued instead; an empty row issues nothing. Reset clears the FSM, pipeline valids and
// row weights and sets expansion_factor to 96. A stall on out freezes the whole pipeline
// and the row walk; in is stalled until the last entry or the bad_config item has issued.
module qc_ldpc_expansion_address_gen_core
  import qcl_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_ROWS = DEF_MAX_BLOCK_ROWS,
  parameter int unsigned MAX_ROW_WEIGHT = DEF_MAX_ROW_WEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [3:0]  block_row,
  input  logic [4:0]  entry_slot,
  input  logic [6:0]  entry_shift,
  input  logic [4:0]  entry_column,
  input  logic        row_end,
  input  logic [6:0]  sub_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] check_node_index,
  output logic [11:0] var_node_index,
  output logic        last,
  output logic        bad_config
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  qcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  qcl_datapath #(
    .MAX_BLOCK_ROWS (MAX_BLOCK_ROWS),
    .MAX_ROW_WEIGHT (MAX_ROW_WEIGHT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .block_row        (block_row),
    .entry_slot       (entry_slot),
    .entry_shift      (entry_shift),
    .entry_column     (entry_column),
    .row_end          (row_end),
    .sub_row          (sub_row),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .check_node_index (check_node_index),
    .var_node_index   (var_node_index),
    .last             (last),
    .bad_config       (bad_config)
  );

endmodule

// File: hw/rtl/qcl_ctrl.sv
module qcl_ctrl
  import qcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    req_type,
  input  dp_sts_t sts,
  output logic    in_stall,
  output dp_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_EXPAND) begin
            cmd.capture = 1'b1;
            state_next  = ST_MOD;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_MOD: begin
        if (sts.z_bad) begin
          state_next = ST_BAD;
        end else if (sts.row_skip) begin
          state_next = ST_IDLE;
        end else if (sts.d_ge_z) begin
          cmd.mod_sub = 1'b1;
        end else begin
          cmd.start_walk = 1'b1;
          state_next     = ST_WALK;
        end
      end
      ST_BAD: begin
        if (sts.adv) begin
          cmd.issue_bad = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (sts.adv) begin
          cmd.issue = 1'b1;
          if (sts.k_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/qcl_datapath.sv
module qcl_datapath
  import qcl_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_ROWS = DEF_MAX_BLOCK_ROWS,
  parameter int unsigned MAX_ROW_WEIGHT = DEF_MAX_ROW_WEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        cfg_valid,
  input  logic [6:0]  cfg_data,
  input  logic [3:0]  block_row,
  input  logic [4:0]  entry_slot,
  input  logic [6:0]  entry_shift,
  input  logic [4:0]  entry_column,
  input  logic        row_end,
  input  logic [6:0]  sub_row,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [10:0] check_node_index,
  output logic [11:0] var_node_index,
  output logic        last,
  output logic        bad_config
);

  localparam int unsigned DEPTH  = MAX_BLOCK_ROWS * MAX_ROW_WEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RIDX_W = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;

  logic [6:0]  z;
  logic [4:0]  row_weight [MAX_BLOCK_ROWS];
  logic [11:0] mem [DEPTH];

  logic              in_row_ok;
  logic              in_slot_ok;
  logic [RIDX_W-1:0] in_ridx;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [4:0]        w_in;
  logic              adv;
  logic              z_ok;

  logic [3:0]        brow;
  logic [6:0]        dr;
  logic [4:0]        w;
  logic [4:0]        k;
  logic [ADDR_W-1:0] base;
  logic [10:0]       cn;

  logic [11:0] rdata;
  logic        s1_v;
  logic        s1_bad;
  logic        s1_last;
  logic [6:0]  s1_d;
  logic [10:0] s1_cn;

  logic        s2_v;
  logic        s2_bad;
  logic        s2_last;
  logic [6:0]  s2_d;
  logic [10:0] s2_cn;
  logic [13:0] s2_prod;
  logic [11:0] s2_colz;

  logic        s3_v;
  logic        s3_bad;
  logic        s3_last;
  logic [6:0]  s3_d;
  logic [10:0] s3_cn;
  logic [6:0]  s3_scaled;
  logic [11:0] s3_colz;

  logic [17:0] recip_prod;
  logic [7:0]  sum;
  logic [7:0]  sum_mod;
  logic [7:0]  z8;

  assign adv        = !out_valid || !out_stall;
  assign z_ok       = (z >= Z_MIN) && (z <= Z_MAX) && ((z & Z_STEP_MASK) == 7'd0);
  assign in_row_ok  = 32'(block_row) < MAX_BLOCK_ROWS;
  assign in_slot_ok = 32'(entry_slot) < MAX_ROW_WEIGHT;
  assign in_ridx    = RIDX_W'(block_row);
  assign wr_addr    = ADDR_W'(32'(block_row) * MAX_ROW_WEIGHT + 32'(entry_slot));
  assign rd_addr    = base + ADDR_W'(k);

  always_comb begin
    w_in = 5'd0;
    if (in_row_ok) begin
      w_in = row_weight[in_ridx];
      if (32'(w_in) > MAX_ROW_WEIGHT) begin
        w_in = 5'(MAX_ROW_WEIGHT);
      end
    end
  end

  assign sts.adv      = adv;
  assign sts.z_bad    = !z_ok;
  assign sts.row_skip = (w == 5'd0);
  assign sts.d_ge_z   = (dr >= z);
  assign sts.k_last   = (k == w - 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      z <= Z_RESET;
    end else if (cfg_valid) begin
      z <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BLOCK_ROWS; i++) begin
        row_weight[i] <= '0;
      end
    end else if (cmd.load && in_row_ok && in_slot_ok && row_end) begin
      row_weight[in_ridx] <= entry_slot + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_row_ok && in_slot_ok) begin
      mem[wr_addr] <= {entry_shift, entry_column};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      brow <= block_row;
      dr   <= sub_row;
      w    <= w_in;
    end else if (cmd.mod_sub) begin
      dr <= dr - z;
    end
    if (cmd.start_walk) begin
      base <= ADDR_W'(32'(brow) * MAX_ROW_WEIGHT);
      cn   <= 11'({7'd0, brow} * {4'd0, z}) + 11'(dr);
      k    <= 5'd0;
    end else if (cmd.issue) begin
      k <= k + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= cmd.issue || cmd.issue_bad;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
  end

  assign recip_prod = (18'(s2_prod) >> SCALE_SHIFT) * 18'(SCALE_RECIP);
  assign z8         = {1'b0, z};
  assign sum        = {1'b0, s3_scaled} + {1'b0, s3_d};

  always_comb begin
    if (sum >= (z8 << 1)) begin
      sum_mod = sum - (z8 << 1);
    end else if (sum >= z8) begin
      sum_mod = sum - z8;
    end else begin
      sum_mod = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bad  <= cmd.issue_bad;
      s1_last <= sts.k_last;
      s1_d    <= dr;
      s1_cn   <= cn;

      s2_bad  <= s1_bad;
      s2_last <= s1_last;
      s2_d    <= s1_d;
      s2_cn   <= s1_cn;
      s2_prod <= {7'd0, rdata[11:5]} * {7'd0, z};
      s2_colz <= {7'd0, rdata[4:0]} * {5'd0, z};

      s3_bad    <= s2_bad;
      s3_last   <= s2_last;
      s3_d      <= s2_d;
      s3_cn     <= s2_cn;
      s3_scaled <= 7'(recip_prod >> SCALE_RECIP_SHIFT);
      s3_colz   <= s2_colz;

      if (s3_bad) begin
        check_node_index <= 11'd0;
        var_node_index   <= 12'd0;
        last             <= 1'b0;
        bad_config       <= 1'b1;
      end else begin
        check_node_index <= s3_cn;
        var_node_index   <= {4'd0, sum_mod} + s3_colz;
        last             <= s3_last;
        bad_config       <= 1'b0;
      end
    end
  end

  a_issue_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue || cmd.issue_bad) |-> adv)
    else $error("item issued into stalled pipeline");

  a_walk_in_row: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (k < w))
    else $error("row walk past row weight");

  a_walk_start_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.start_walk |-> ((dr < z) && (w != 5'd0) && z_ok))
    else $error("row walk started with unreduced sub-row or empty row");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_bad |=> !cmd.issue && !cmd.issue_bad)
    else $error("more than one bad-config item issued");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb
  import qcl_pkg::*;
();

  localparam int unsigned ROWS          = DEF_MAX_BLOCK_ROWS;
  localparam int unsigned ROW_SLOTS     = DEF_MAX_ROW_WEIGHT;
  localparam int unsigned SHIFT_BASE_Z  = 96;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct {
    logic       kind;
    logic [3:0] row;
    logic [4:0] slot;
    logic [6:0] shift;
    logic [4:0] col;
    logic       rend;
    logic [6:0] d;
    bit         drain_first;
  } conn_req_t;

  typedef struct {
    logic [10:0] cn;
    logic [11:0] vn;
    logic        last;
    logic        bad;
  } conn_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [3:0]  block_row = '0;
  logic [4:0]  entry_slot = '0;
  logic [6:0]  entry_shift = '0;
  logic [4:0]  entry_column = '0;
  logic        row_end = 1'b0;
  logic [6:0]  sub_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] check_node_index;
  logic [11:0] var_node_index;
  logic        last;
  logic        bad_config;

  // predictor state
  logic [6:0] tbl_shift [ROWS*ROW_SLOTS];
  logic [4:0] tbl_col [ROWS*ROW_SLOTS];
  logic [4:0] row_wt [ROWS];
  logic [6:0] z_cur = Z_RESET;

  conn_req_t pending_reqs[$];
  conn_t     expected_conns[$];
  conn_req_t cur_req;
  conn_t     exp_c;
  bit        in_taken = 1'b0;
  int        tx_gap = 0;
  int        rx_run = 0;
  int        rx_hold = 0;
  bit        tx_quiet = 1'b0;
  bit        rx_quiet = 1'b0;
  int        mismatch_count = 0;
  int        items_queued = 0;
  bit        entry_set [ROWS][ROW_SLOTS];

  qc_ldpc_expansion_address_gen_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .block_row        (block_row),
    .entry_slot       (entry_slot),
    .entry_shift      (entry_shift),
    .entry_column     (entry_column),
    .row_end          (row_end),
    .sub_row          (sub_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .check_node_index (check_node_index),
    .var_node_index   (var_node_index),
    .last             (last),
    .bad_config       (bad_config)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL qc_ldpc_expansion_address_gen_core");
    $finish;
  end

  function automatic bit z_ok(input int unsigned z);
    return z >= Z_MIN && z <= Z_MAX && (z & Z_STEP_MASK) == 0;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic predict_connections(input conn_req_t rq);
    int unsigned z, a, w, d, scaled, vn, cn;
    conn_t c;
    z = 32'(z_cur);
    if (rq.kind == REQ_LOAD) begin
      if (rq.row < ROWS && rq.slot < ROW_SLOTS) begin
        a = rq.row * ROW_SLOTS + rq.slot;
        tbl_shift[a] = rq.shift;
        tbl_col[a] = rq.col;
        if (rq.rend) row_wt[rq.row] = 5'(rq.slot + 1);
      end
    end else if (!z_ok(z)) begin
      c = '{cn: '0, vn: '0, last: 1'b0, bad: 1'b1};
      expected_conns = {expected_conns, c};
    end else if (rq.row < ROWS) begin
      w = 32'(row_wt[rq.row]);
      if (w > ROW_SLOTS) w = ROW_SLOTS;
      d = rq.d % z;
      cn = rq.row * z + d;
      for (int unsigned k = 0; k < w; k++) begin
        a = rq.row * ROW_SLOTS + k;
        scaled = (tbl_shift[a] * z) / SHIFT_BASE_Z;
        vn = (scaled + d) % z + tbl_col[a] * z;
        c.cn = cn[10:0];
        c.vn = vn[11:0];
        c.last = (k + 1 == w);
        c.bad = 1'b0;
        expected_conns = {expected_conns, c};
      end
    end
  endtask

  // sample acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_connections(cur_req);
      in_taken = 1'b1;
    end
  end

  // drive request items
  always @(negedge clk) begin
    if (!rst && (in_taken || !in_valid)) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   (!pending_reqs[0].drain_first || expected_conns.size() == 0)) begin
        cur_req = pending_reqs.pop_front();
        req_type     <= cur_req.kind;
        block_row    <= cur_req.row;
        entry_slot   <= cur_req.slot;
        entry_shift  <= cur_req.shift;
        entry_column <= cur_req.col;
        row_end      <= cur_req.rend;
        sub_row      <= cur_req.d;
        in_valid     <= 1'b1;
        tx_gap = tx_quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      if (rx_run == 0 && !rx_quiet) rx_run = pick_gap();
      if (rx_run > 0) begin
        out_stall <= 1'b1;
        rx_run--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // check results
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_conns.size() == 0) begin
        flag_mismatch($sformatf("unexpected item cn=%0d vn=%0d last=%0b bad=%0b",
                                check_node_index, var_node_index, last, bad_config));
      end else begin
        exp_c = expected_conns.pop_front();
        if (check_node_index !== exp_c.cn)
          flag_mismatch($sformatf("check_node_index got %0d exp %0d",
                                  check_node_index, exp_c.cn));
        if (var_node_index !== exp_c.vn)
          flag_mismatch($sformatf("var_node_index got %0d exp %0d", var_node_index, exp_c.vn));
        if (last !== exp_c.last)
          flag_mismatch($sformatf("last got %0b exp %0b", last, exp_c.last));
        if (bad_config !== exp_c.bad)
          flag_mismatch($sformatf("bad_config got %0b exp %0b", bad_config, exp_c.bad));
      end
    end
  end

  task automatic push_load(input int unsigned row, input int unsigned slot,
                           input int unsigned shift, input int unsigned col,
                           input bit rend, input bit drain_first = 1'b0);
    conn_req_t rq;
    rq = '{kind: REQ_LOAD, row: 4'(row), slot: 5'(slot), shift: 7'(shift), col: 5'(col),
           rend: rend, d: 7'($urandom_range(0, 127)), drain_first: drain_first};
    if (row < ROWS && slot < ROW_SLOTS) entry_set[row][slot] = 1'b1;
    pending_reqs = {pending_reqs, rq};
    items_queued++;
  endtask

  task automatic push_expand(input int unsigned row, input int unsigned d,
                             input bit drain_first = 1'b0);
    conn_req_t rq;
    rq = '{kind: REQ_EXPAND, row: 4'(row), slot: 5'($urandom_range(0, 31)),
           shift: 7'($urandom_range(0, 127)), col: 5'($urandom_range(0, 31)),
           rend: 1'($urandom_range(0, 1)), d: 7'(d), drain_first: drain_first};
    pending_reqs = {pending_reqs, rq};
    items_queued++;
  endtask

  function automatic bit prefix_set(input int unsigned row, input int unsigned slot);
    for (int unsigned i = 0; i <= slot; i++)
      if (!entry_set[row][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_d();
    if (z_ok(z_cur) && $urandom_range(0, 9) < 8) return $urandom_range(0, z_cur - 1);
    return $urandom_range(0, 127);
  endfunction

  task automatic load_row(input int unsigned row, input int unsigned w);
    int unsigned sh, cl;
    for (int unsigned s = 0; s < w; s++) begin
      sh = ($urandom_range(0, 9) == 0) ? $urandom_range(96, 127) : $urandom_range(0, 95);
      cl = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
      push_load(row, s, sh, cl, s == w - 1);
    end
  endtask

  task automatic run_random(input int n);
    int target, r;
    int unsigned row, slot, w;
    target = items_queued + n;
    while (items_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        row = $urandom_range(0, ROWS - 1);
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(7, ROW_SLOTS) : $urandom_range(1, 6);
        load_row(row, w);
        repeat ($urandom_range(1, 3)) push_expand(row, pick_d(), $urandom_range(0, 19) == 0);
      end else if (r < 80) begin
        push_expand($urandom_range(0, ROWS - 1), pick_d());
      end else if (r < 90) begin
        row = $urandom_range(0, 15);
        slot = $urandom_range(0, 31);
        push_load(row, slot, $urandom_range(0, 127), $urandom_range(0, 31),
                  (row >= ROWS || slot >= ROW_SLOTS || prefix_set(row, slot)) ?
                  1'($urandom_range(0, 1)) : 1'b0);
      end else begin
        push_expand($urandom_range(0, 15), $urandom_range(0, 127));
      end
    end
  endtask

  task automatic write_z(input logic [6:0] z);
    @(negedge clk);
    cfg_data  <= z;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    z_cur = z;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_conns.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < ROWS; i++) row_wt[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_z(Z_RESET);
    push_load(0, 0, 0, 0, 1'b0);
    push_load(0, 1, 95, 23, 1'b0);
    push_load(0, 2, 127, 31, 1'b1);
    push_load(11, 0, 48, 12, 1'b1);
    push_load(12, 0, 10, 3, 1'b1);
    push_load(15, 31, 127, 31, 1'b1);
    push_load(1, 24, 7, 7, 1'b1);
    push_load(1, 31, 7, 7, 1'b1);
    push_load(1, 0, 1, 1, 1'b0);
    push_expand(0, 0);
    push_expand(0, 95);
    push_expand(0, 127);
    push_expand(11, 64);
    push_expand(1, 3);
    push_expand(5, 0);
    push_expand(12, 0);
    push_expand(15, 127);
    push_load(0, 0, 5, 2, 1'b1, 1'b1);
    push_expand(0, 10);
    wait_idle();

    write_z(Z_MIN);
    load_row(2, ROW_SLOTS);
    push_expand(2, 0);
    push_expand(2, pick_d());
    run_random(6);
    wait_idle();

    write_z(7'd127);
    run_random(3);
    wait_idle();

    // hold the receiver off while the sender keeps the input busy
    write_z(7'd64);
    tx_quiet = 1'b1;
    rx_hold = 400;
    load_row(3, 6);
    repeat (8) push_expand(3, pick_d());
    wait_idle();
    tx_quiet = 1'b0;

    write_z(7'd0);
    run_random(3);
    wait_idle();

    write_z(7'd52);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_random(5);
    wait_idle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    write_z(7'd26);
    run_random(3);
    wait_idle();

    write_z(Z_MAX);
    push_expand(2, pick_d());
    run_random(3);
    wait_idle();

    write_z(7'(4 * $urandom_range(6, 24)));
    push_expand(2, pick_d());
    run_random(3);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("PASS qc_ldpc_expansion_address_gen_core");
    end else begin
      $display("FAIL qc_ldpc_expansion_address_gen_core");
    end
    $finish;
  end

endmodule
